### rtl/core/pi_esc_pkg.sv
// Shared types, constants and helper functions of the incremental PI ESC speed controller.
`default_nettype none

package pi_esc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_MAX       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_MIN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_MAX     = 3'd7;

    localparam logic [15:0] RST_PROP_GAIN     = 16'd7680;
    localparam logic [15:0] RST_INTEG_GAIN    = 16'd640;
    localparam logic [23:0] RST_SPEED_SCALE   = 24'd23815;
    localparam logic [11:0] RST_NEUTRAL_WIDTH = 12'd1500;
    localparam logic [11:0] RST_ESC_MIN       = 12'd1400;
    localparam logic [11:0] RST_ESC_MAX       = 12'd1680;
    localparam logic [11:0] RST_STEER_MIN     = 12'd500;
    localparam logic [11:0] RST_STEER_MAX     = 12'd2500;

    localparam logic [18:0]        ESC_FWD_OFFSET = 19'd33;
    localparam logic [18:0]        ESC_REV_OFFSET = 19'd25;
    localparam logic signed [31:0] HALF_Q16       = 32'sd32768;
    localparam logic signed [31:0] NEG_HALF_Q16   = -32'sd32768;

    localparam logic signed [51:0] SAT_HI = 52'sd2147483647;
    localparam logic signed [51:0] SAT_LO = -52'sd2147483648;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_MEAS  = 3'd2;
    localparam logic [2:0] OP_ERR   = 3'd3;
    localparam logic [2:0] OP_PROP  = 3'd4;
    localparam logic [2:0] OP_INTEG = 3'd5;
    localparam logic [2:0] OP_ACC   = 3'd6;
    localparam logic [2:0] OP_OUT   = 3'd7;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [23:0] speed_scale;
        logic [11:0] neutral_width;
        logic [11:0] esc_min;
        logic [11:0] esc_max;
        logic [11:0] steer_min;
        logic [11:0] steer_max;
    } t_cfg;

    typedef struct packed {
        logic [2:0] op;
    } t_dp_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
        if (x > SAT_HI) begin
            return SAT_HI[31:0];
        end else if (x < SAT_LO) begin
            return SAT_LO[31:0];
        end
        return x[31:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/pi_esc_cfg.sv
// Configuration register file of the incremental PI ESC speed controller.
`default_nettype none

module pi_esc_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pi_esc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pi_esc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pi_esc_pkg::t_cfg                       o_cfg
);
    import pi_esc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain     <= RST_PROP_GAIN;
            r_cfg.integ_gain    <= RST_INTEG_GAIN;
            r_cfg.speed_scale   <= RST_SPEED_SCALE;
            r_cfg.neutral_width <= RST_NEUTRAL_WIDTH;
            r_cfg.esc_min       <= RST_ESC_MIN;
            r_cfg.esc_max       <= RST_ESC_MAX;
            r_cfg.steer_min     <= RST_STEER_MIN;
            r_cfg.steer_max     <= RST_STEER_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROP_GAIN:     r_cfg.prop_gain     <= i_cfg_data[15:0];
                REG_INTEG_GAIN:    r_cfg.integ_gain    <= i_cfg_data[15:0];
                REG_SPEED_SCALE:   r_cfg.speed_scale   <= i_cfg_data[23:0];
                REG_NEUTRAL_WIDTH: r_cfg.neutral_width <= i_cfg_data[11:0];
                REG_ESC_MIN:       r_cfg.esc_min       <= i_cfg_data[11:0];
                REG_ESC_MAX:       r_cfg.esc_max       <= i_cfg_data[11:0];
                REG_STEER_MIN:     r_cfg.steer_min     <= i_cfg_data[11:0];
                REG_STEER_MAX:     r_cfg.steer_max     <= i_cfg_data[11:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/core/pi_esc_dp.sv
// Datapath of the PI ESC controller: shared multiplier, error, accumulator and width clamps.
`default_nettype none

module pi_esc_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pi_esc_pkg::t_dp_cmd i_cmd,
    input  wire pi_esc_pkg::t_cfg    i_cfg,
    input  wire logic signed [15:0]  i_encoder_count,
    input  wire logic signed [31:0]  i_target_speed,
    input  wire logic [15:0]         i_steer_request,
    output logic [11:0]              o_esc_width,
    output logic [11:0]              o_steer_width,
    output logic signed [15:0]       o_drive_level
);
    import pi_esc_pkg::*;

    logic signed [15:0] r_count;
    logic signed [31:0] r_target;
    logic [15:0]        r_steer;
    logic signed [57:0] r_prod;
    logic signed [49:0] r_psum;
    logic signed [31:0] r_err;
    logic signed [31:0] r_last_err;
    logic signed [31:0] r_accum;
    logic [11:0]        r_esc_w;
    logic [11:0]        r_steer_w;
    logic signed [15:0] r_level;

    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] mul_p;
    logic signed [49:0] prod_sh;
    logic signed [51:0] err_sum;
    logic signed [51:0] acc_sum;
    logic               neg_frac;
    logic signed [16:0] t_trunc;
    logic signed [18:0] esc_raw;
    logic signed [18:0] esc_clamp;
    logic signed [18:0] esc_lo;
    logic signed [18:0] esc_hi;
    logic [15:0]        steer_clamp;

    always_comb begin
        unique case (i_cmd.op)
            OP_MEAS: begin
                mul_a = 33'(r_count);
                mul_b = {1'b0, i_cfg.speed_scale};
            end
            OP_PROP: begin
                mul_a = 33'(r_err) - 33'(r_last_err);
                mul_b = {9'b0, i_cfg.prop_gain};
            end
            default: begin
                mul_a = 33'(r_err);
                mul_b = {9'b0, i_cfg.integ_gain};
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign prod_sh = $signed(r_prod[57:8]);
    assign err_sum = 52'(r_target) + 52'(prod_sh);
    assign acc_sum = 52'(r_accum) + 52'(r_psum) + 52'(prod_sh);

    assign neg_frac = r_accum[31] && (r_accum[15:0] != 16'd0);
    assign t_trunc  = {r_accum[31], r_accum[31:16]} + {16'b0, neg_frac};
    assign esc_lo   = {7'b0, i_cfg.esc_min};
    assign esc_hi   = {7'b0, i_cfg.esc_max};

    always_comb begin
        priority if (r_accum > HALF_Q16) begin
            esc_raw = {7'b0, i_cfg.neutral_width} + ESC_FWD_OFFSET + {{2{t_trunc[16]}}, t_trunc};
        end else if (r_accum < NEG_HALF_Q16) begin
            esc_raw = {7'b0, i_cfg.neutral_width} - ESC_REV_OFFSET + {{2{t_trunc[16]}}, t_trunc};
        end else begin
            esc_raw = {7'b0, i_cfg.neutral_width};
        end
        esc_clamp = (esc_raw > esc_hi) ? esc_hi : esc_raw;
        if (esc_clamp < esc_lo) begin
            esc_clamp = esc_lo;
        end
        steer_clamp = (r_steer > {4'b0, i_cfg.steer_max}) ? {4'b0, i_cfg.steer_max} : r_steer;
        if (steer_clamp < {4'b0, i_cfg.steer_min}) begin
            steer_clamp = {4'b0, i_cfg.steer_min};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum    <= '0;
            r_last_err <= '0;
        end else begin
            if (i_cmd.op == OP_PROP) begin
                r_last_err <= r_err;
            end
            if (i_cmd.op == OP_ACC) begin
                r_accum <= sat32(acc_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_count  <= i_encoder_count;
                r_target <= i_target_speed;
                r_steer  <= i_steer_request;
            end
            OP_MEAS, OP_PROP: begin
                r_prod <= mul_p;
            end
            OP_ERR: begin
                r_err <= sat32(err_sum);
            end
            OP_INTEG: begin
                r_psum <= prod_sh;
                r_prod <= mul_p;
            end
            OP_OUT: begin
                r_esc_w   <= esc_clamp[11:0];
                r_steer_w <= steer_clamp[11:0];
                r_level   <= t_trunc[15:0];
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    assign o_esc_width   = r_esc_w;
    assign o_steer_width = r_steer_w;
    assign o_drive_level = r_level;

endmodule

`default_nettype wire

### rtl/core/pi_esc_ctrl.sv
// Sequencing state machine and output valid register of the PI ESC controller.
`default_nettype none

module pi_esc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output pi_esc_pkg::t_dp_cmd o_cmd
);
    import pi_esc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MEAS  = 3'd1;
    localparam logic [2:0] ST_ERR   = 3'd2;
    localparam logic [2:0] ST_PROP  = 3'd3;
    localparam logic [2:0] ST_INTEG = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_load;

    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_MEAS;
                end
            end
            ST_MEAS: begin
                o_cmd.op = OP_MEAS;
                n_state  = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = ST_PROP;
            end
            ST_PROP: begin
                o_cmd.op = OP_PROP;
                n_state  = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.op = OP_INTEG;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_MEAS))
        else $error("accepted item did not start the sequence");

    a_acc_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |=> (r_state == ST_OUT))
        else $error("accumulate step not followed by output step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && r_out_valid && !i_out_ready) |=> (r_state == ST_OUT))
        else $error("pending result overwritten");

    a_out_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("result load did not raise valid");

endmodule

`default_nettype wire

### rtl/core/incremental_pi_esc_speed_control.sv
// Top level of the incremental PI ESC speed controller with steering clamp.
// An accepted item passes the measure, error, proportional, integral and accumulate steps
// before its result is loaded into the output register; the load waits while an earlier
// result is still not taken. One shared 33 x 25 bit multiplier is used in turn for the speed
// scaling, the proportional term and the integral term, each product registered before the
// error, accumulate and width steps. A new item is accepted once the previous result is
// loaded into the output register, even while that result still waits to be taken.
// Configuration must be written only while idle; the block itself does not enforce it.
`default_nettype none

module incremental_pi_esc_speed_control (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pi_esc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pi_esc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // encoder_count[15:0], target_speed[47:16], steer_request[63:48]
    input  wire logic [63:0]                       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // esc_width[11:0], steer_width[23:12], drive_level[39:24]
    output logic [39:0]                            m_axis_tdata
);
    import pi_esc_pkg::*;

    t_cfg               cfg;
    t_dp_cmd            cmd;
    logic [11:0]        esc_width;
    logic [11:0]        steer_width;
    logic signed [15:0] drive_level;

    pi_esc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pi_esc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    pi_esc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (cfg),
        .i_encoder_count ($signed(s_axis_tdata[15:0])),
        .i_target_speed  ($signed(s_axis_tdata[47:16])),
        .i_steer_request (s_axis_tdata[63:48]),
        .o_esc_width     (esc_width),
        .o_steer_width   (steer_width),
        .o_drive_level   (drive_level)
    );

    assign m_axis_tdata = {drive_level, steer_width, esc_width};

endmodule

`default_nettype wire

### verif/incremental_pi_esc_speed_control_checker.sv
// Checker that predicts the ESC, steering and drive results of each tick and compares them.
module incremental_pi_esc_speed_control_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pi_esc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pi_esc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    // encoder_count[15:0], target_speed[47:16], steer_request[63:48]
    input  wire logic [63:0]                       s_axis_tdata,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // esc_width[11:0], steer_width[23:12], drive_level[39:24]
    input  wire logic [39:0]                       m_axis_tdata,
    output int                                     o_pending,
    output int                                     o_error_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import pi_esc_pkg::*;

    typedef struct {
        logic [11:0] esc;
        logic [11:0] steer;
        logic [15:0] drive;
    } t_widths;

    t_cfg               speed_cfg;
    logic signed [31:0] drive_accum_q;
    logic signed [31:0] last_error_q;
    t_widths            expected_widths[$];
    int                 mismatches = 0;

    function automatic longint clip32(input longint x);
        if (x > longint'(32'sh7FFF_FFFF)) begin
            return longint'(32'sh7FFF_FFFF);
        end else if (x < longint'(32'sh8000_0000)) begin
            return longint'(32'sh8000_0000);
        end
        return x;
    endfunction

    function automatic longint clamp_range(input longint w, input longint lo, input longint hi);
        if (w > hi) begin
            w = hi;
        end
        if (w < lo) begin
            w = lo;
        end
        return w;
    endfunction

    // Advances the controller state by one tick and returns the widths it produces.
    function automatic t_widths predict_widths(input logic [63:0] tick);
        longint  cnt, target, steer, meas, err, prop_term, integ_term, u, whole, esc;
        t_widths w;
        cnt        = longint'($signed(tick[15:0]));
        target     = longint'($signed(tick[47:16]));
        steer      = longint'(tick[63:48]);
        meas       = -((cnt * longint'(speed_cfg.speed_scale)) >>> 8);
        err        = clip32(target - meas);
        prop_term  = (longint'(speed_cfg.prop_gain) * (err - longint'(last_error_q))) >>> 8;
        integ_term = (longint'(speed_cfg.integ_gain) * err) >>> 8;
        u          = clip32(longint'(drive_accum_q) + prop_term + integ_term);
        drive_accum_q = u[31:0];
        last_error_q  = err[31:0];
        whole = (u >= 0) ? (u >>> 16) : -((-u) >>> 16);
        if (u > longint'(HALF_Q16)) begin
            esc = longint'(speed_cfg.neutral_width) + longint'(ESC_FWD_OFFSET) + whole;
        end else if (u < longint'(NEG_HALF_Q16)) begin
            esc = longint'(speed_cfg.neutral_width) - longint'(ESC_REV_OFFSET) + whole;
        end else begin
            esc = longint'(speed_cfg.neutral_width);
        end
        esc   = clamp_range(esc, longint'(speed_cfg.esc_min), longint'(speed_cfg.esc_max));
        steer = clamp_range(steer, longint'(speed_cfg.steer_min), longint'(speed_cfg.steer_max));
        w.esc   = esc[11:0];
        w.steer = steer[11:0];
        w.drive = whole[15:0];
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_widths exp_w;
        if (!i_rst_n) begin
            speed_cfg.prop_gain     = RST_PROP_GAIN;
            speed_cfg.integ_gain    = RST_INTEG_GAIN;
            speed_cfg.speed_scale   = RST_SPEED_SCALE;
            speed_cfg.neutral_width = RST_NEUTRAL_WIDTH;
            speed_cfg.esc_min       = RST_ESC_MIN;
            speed_cfg.esc_max       = RST_ESC_MAX;
            speed_cfg.steer_min     = RST_STEER_MIN;
            speed_cfg.steer_max     = RST_STEER_MAX;
            drive_accum_q = '0;
            last_error_q  = '0;
            expected_widths.delete();
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PROP_GAIN:     speed_cfg.prop_gain     = i_cfg_data[15:0];
                    REG_INTEG_GAIN:    speed_cfg.integ_gain    = i_cfg_data[15:0];
                    REG_SPEED_SCALE:   speed_cfg.speed_scale   = i_cfg_data[23:0];
                    REG_NEUTRAL_WIDTH: speed_cfg.neutral_width = i_cfg_data[11:0];
                    REG_ESC_MIN:       speed_cfg.esc_min       = i_cfg_data[11:0];
                    REG_ESC_MAX:       speed_cfg.esc_max       = i_cfg_data[11:0];
                    REG_STEER_MIN:     speed_cfg.steer_min     = i_cfg_data[11:0];
                    REG_STEER_MAX:     speed_cfg.steer_max     = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_widths.size() == 0) begin
                    $error("result item with nothing expected: %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    exp_w = expected_widths.pop_front();
                    if (m_axis_tdata[11:0] !== exp_w.esc) begin
                        $error("esc_width: expected %0d, actual %0d",
                               exp_w.esc, m_axis_tdata[11:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[23:12] !== exp_w.steer) begin
                        $error("steer_width: expected %0d, actual %0d",
                               exp_w.steer, m_axis_tdata[23:12]);
                        mismatches++;
                    end
                    if (m_axis_tdata[39:24] !== exp_w.drive) begin
                        $error("drive_level: expected %0d, actual %0d",
                               $signed(exp_w.drive), $signed(m_axis_tdata[39:24]));
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_widths.push_back(predict_widths(s_axis_tdata));
            end
        end
        o_pending     <= expected_widths.size();
        o_error_count <= mismatches;
    end

endmodule

### verif/incremental_pi_esc_speed_control_test.sv
// Testbench top that drives ticks and register settings into the speed controller.
module incremental_pi_esc_speed_control_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pi_esc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;

    int pending;
    int error_count;
    int stim_phase  = 0;
    bit quiet       = 1'b0;
    int cycle_count = 0;

    always #6 i_clk = ~i_clk;

    incremental_pi_esc_speed_control dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    incremental_pi_esc_speed_control_checker tick_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_pending     (pending),
        .o_error_count (error_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("incremental_pi_esc_speed_control_test: errors");
            $finish;
        end
    end

    function automatic logic [63:0] pack_tick(input logic [15:0] cnt, input logic [31:0] target,
                                              input logic [15:0] steer);
        return {steer, target, cnt};
    endfunction

    function automatic logic [63:0] random_tick();
        logic [15:0] cnt;
        logic [31:0] target;
        logic [15:0] steer;
        cnt    = 16'($urandom);
        target = $urandom;
        steer  = 16'($urandom);
        case ($urandom_range(0, 4))
            0: ;
            1: begin
                cnt    = 16'(int'($urandom_range(0, 6)) - 3);
                target = 32'(int'($urandom_range(0, 8000)) - 4000);
                steer  = 16'($urandom_range(0, 4095));
            end
            default: begin
                cnt    = 16'(int'($urandom_range(0, 400)) - 200);
                target = 32'(int'($urandom_range(0, 524288)) - 262144);
                steer  = 16'($urandom_range(0, 3000));
            end
        endcase
        return pack_tick(cnt, target, steer);
    endfunction

    task automatic send_tick(input logic [63:0] tick);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tick;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_tick(random_tick());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] prop, input logic [15:0] integ,
                                 input logic [23:0] scale, input logic [11:0] neutral,
                                 input logic [11:0] esc_lo, input logic [11:0] esc_hi,
                                 input logic [11:0] steer_lo, input logic [11:0] steer_hi);
        write_reg(REG_PROP_GAIN, 24'(prop));
        write_reg(REG_INTEG_GAIN, 24'(integ));
        write_reg(REG_SPEED_SCALE, scale);
        write_reg(REG_NEUTRAL_WIDTH, 24'(neutral));
        write_reg(REG_ESC_MIN, 24'(esc_lo));
        write_reg(REG_ESC_MAX, 24'(esc_hi));
        write_reg(REG_STEER_MIN, 24'(steer_lo));
        write_reg(REG_STEER_MAX, 24'(steer_hi));
        i_cfg_we <= 1'b0;
    endtask

    initial begin : result_sink
        bit held;
        int span;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && stim_phase == 1) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (quiet) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                span = $urandom_range(1, 16);
                m_axis_tready <= ($urandom_range(0, 2) != 0);
                repeat (span) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: dead band, both drive directions, saturation and width clamps.
        send_tick(pack_tick(16'sd0, 32'sd0, 16'd1500));
        send_tick(pack_tick(16'sd0, 32'sd1000, 16'd1500));
        send_tick(pack_tick(16'sd0, 32'sd0, 16'd1500));
        send_tick(pack_tick(16'sd0, 32'sh0001_0000, 16'd1500));
        send_tick(pack_tick(16'sd0, -32'sh0002_0000, 16'd1500));
        send_tick(pack_tick(16'sd0, -32'sh0002_0000, 16'd1500));
        send_tick(pack_tick(16'sh7FFF, 32'sh7FFF_FFFF, 16'hFFFF));
        send_tick(pack_tick(16'sh7FFF, 32'sh7FFF_FFFF, 16'hFFFF));
        send_tick(pack_tick(16'sh8000, 32'sh8000_0000, 16'h0000));
        send_tick(pack_tick(16'sh8000, 32'sh8000_0000, 16'h0000));
        send_tick(pack_tick(16'sh8000, 32'sh8000_0000, 16'h0000));
        send_tick(pack_tick(16'sh7FFF, 32'sd0, 16'd2500));
        send_tick(pack_tick(-16'sd1, 32'sd1, 16'd499));
        send_tick(pack_tick(16'sd1, -32'sd1, 16'd2501));
        send_tick(pack_tick(16'sd100, 32'sd0, 16'd500));
        send_tick(pack_tick(-16'sd100, 32'sd0, 16'd4096));
        send_tick(pack_tick(16'h5555, 32'hAAAA_AAAA, 16'h5555));
        send_tick(pack_tick(16'hAAAA, 32'h5555_5555, 16'hAAAA));

        stim_phase = 1;
        send_random(150);
        drain();

        stim_phase = 2;
        load_settings(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 12'hFFF, 12'd0, 12'hFFF, 12'd0, 12'hFFF);
        send_random(100);
        drain();

        stim_phase = 3;
        load_settings(16'd0, 16'd0, 24'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_random(60);
        drain();

        // Minimum above maximum on both widths, neutral outside the ESC limits.
        stim_phase = 4;
        load_settings(16'd256, 16'd16, 24'd23815, 12'd50, 12'd3000, 12'd1000, 12'd4000, 12'd100);
        send_random(120);
        drain();

        stim_phase = 5;
        load_settings(16'($urandom), 16'($urandom), 24'($urandom), 12'($urandom),
                      12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        send_random(140);
        drain();

        stim_phase = 6;
        load_settings(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 255)),
                      24'($urandom_range(0, 65535)), 12'($urandom_range(1300, 1700)),
                      12'($urandom_range(900, 1500)), 12'($urandom_range(1500, 2100)),
                      12'($urandom_range(400, 1200)), 12'($urandom_range(1800, 2600)));
        send_random(140);
        drain();

        stim_phase = 7;
        quiet = 1'b1;
        load_settings(RST_PROP_GAIN, RST_INTEG_GAIN, RST_SPEED_SCALE, RST_NEUTRAL_WIDTH,
                      RST_ESC_MIN, RST_ESC_MAX, RST_STEER_MIN, RST_STEER_MAX);
        send_random(140);
        drain();

        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("incremental_pi_esc_speed_control_test: clean");
        end else begin
            $display("incremental_pi_esc_speed_control_test: errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/pi_esc_pkg.sv
rtl/core/pi_esc_cfg.sv
rtl/core/pi_esc_dp.sv
rtl/core/pi_esc_ctrl.sv
rtl/core/incremental_pi_esc_speed_control.sv
verif/incremental_pi_esc_speed_control_checker.sv
verif/incremental_pi_esc_speed_control_test.sv
